FILE: hdl/ags_pkg.sv
// Shared types, register indexes and constant helpers for the gain step block.
`timescale 1ns / 1ps
`default_nettype none
package ags_pkg;

  // Register map: index is paddr[4:2]
  localparam int AGS_ADDR_W = 5;
  localparam int AGS_IDX_W  = 3;
  localparam logic [AGS_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [AGS_IDX_W-1:0] REG_TARGET_RMS   = 3'd1;
  localparam logic [AGS_IDX_W-1:0] REG_RATIO_MAX    = 3'd2;
  localparam logic [AGS_IDX_W-1:0] REG_RATIO_MIN    = 3'd3;
  localparam logic [AGS_IDX_W-1:0] REG_CLIP_BACKOFF = 3'd4;
  localparam logic [AGS_IDX_W-1:0] REG_AMP_FLOOR    = 3'd5;
  localparam logic [AGS_IDX_W-1:0] REG_AMP_CEILING  = 3'd6;

  // Field widths
  localparam int AGS_AMP_W = 16;
  localparam int AGS_RMS_W = 15;  // measured RMS after negatives are forced to zero
  localparam int AGS_RAT_W = 17;  // clamped ratio, holds 1.0 at the widest fraction

  // Path an item takes through the datapath
  typedef enum logic [2:0] {
    BR_PASS,
    BR_UP_MINV,
    BR_UP_DIV,
    BR_DN_CLIP,
    BR_DN_DIV
  } ags_br_e;

  // Per-item sideband carried along the pipeline
  typedef struct packed {
    ags_br_e                br;
    logic [AGS_AMP_W-1:0]   amp;
    logic [AGS_AMP_W-1:0]   step;
  } ags_side_t;

  // Configuration register set
  typedef struct packed {
    logic        enable;
    logic [15:0] target_rms;
    logic [15:0] ratio_max;
    logic [12:0] ratio_min;
    logic [12:0] clip_backoff;
    logic [15:0] amp_floor;
    logic [15:0] amp_ceiling;
  } ags_cfg_t;

  // Percentage of 1.0 rounded to nearest at the given fraction width
  function automatic int ags_round_pct(input int frac_bits, input int pct);
    return ((1 << frac_bits) * pct + 50) / 100;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ags_div.sv
// Pipelined restoring divider, one quotient bit per stage, sideband alongside.
`timescale 1ns / 1ps
`default_nettype none
module ags_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 15
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic [NUM_W-1:0]     num_i,
  input  wire logic [DEN_W-1:0]     den_i,
  input  wire ags_pkg::ags_side_t   side_i,
  output logic                      valid_o,
  output logic [NUM_W-1:0]          quot_o,
  output ags_pkg::ags_side_t        side_o
);
  import ags_pkg::*;

  // Stage k holds the partial remainder and the numerator/quotient shift word
  logic             vld_q  [NUM_W+1];
  logic [NUM_W-1:0] nq_q   [NUM_W+1];
  logic [DEN_W-1:0] rem_q  [NUM_W+1];
  logic [DEN_W-1:0] den_q  [NUM_W+1];
  ags_side_t        side_q [NUM_W+1];

  assign vld_q[0]  = valid_i;
  assign nq_q[0]   = num_i;
  assign rem_q[0]  = '0;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    // Bring down the next numerator bit and try the subtract
    assign trial = {rem_q[k], nq_q[k][NUM_W-1]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign ge    = (trial >= {1'b0, den_q[k]});

    // Advance the valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    // Advance remainder, quotient bits and sideband
    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq_q[k+1]   <= {nq_q[k][NUM_W-2:0], ge};
      den_q[k+1]  <= den_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[NUM_W];
  assign quot_o  = nq_q[NUM_W];
  assign side_o  = side_q[NUM_W];

endmodule
`default_nettype wire

FILE: hdl/ags_back.sv
// Back end: ratio clamp, multiply, step select, step limit and amplitude clamp stages.
`timescale 1ns / 1ps
`default_nettype none
module ags_back #(
  parameter int FRAC_BITS = 12,
  parameter int NUM_W     = 28
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ags_pkg::ags_cfg_t    cfg_i,
  input  wire logic                 valid_i,
  input  wire logic [NUM_W-1:0]     quot_i,
  input  wire ags_pkg::ags_side_t   side_i,
  output logic                      done_o,
  output logic [15:0]               next_amp_o,
  output logic                      at_limit_o
);
  import ags_pkg::*;

  localparam int ONE_Q  = 1 << FRAC_BITS;
  localparam int PROD_W = AGS_AMP_W + AGS_RAT_W;
  localparam int DES_W  = PROD_W - FRAC_BITS;
  localparam int LIM_W  = DES_W + 1;

  localparam logic [AGS_RAT_W-1:0] ONE_R = AGS_RAT_W'(ONE_Q);
  localparam logic [NUM_W-1:0]     ONE_N = NUM_W'(ONE_Q);

  // Stage registers
  logic                   rt_vld_q, pm_vld_q, ds_vld_q, lm_vld_q, done_q;
  ags_side_t              rt_side_q, pm_side_q, ds_side_q, lm_side_q;
  logic [AGS_RAT_W-1:0]   rt_ratio_d, rt_ratio_q;
  logic [PROD_W-1:0]      pm_prod_d, pm_prod_q;
  logic [DES_W-1:0]       ds_des_d, ds_des_q;
  logic signed [LIM_W-1:0] lm_lim_d, lm_lim_q;
  logic [15:0]            next_amp_d, next_amp_q;
  logic                   at_limit_d, at_limit_q;

  // Ratio clamp
  logic [NUM_W-1:0] rmax_n, rmin_n;
  assign rmax_n = {{(NUM_W-16){1'b0}}, cfg_i.ratio_max};
  assign rmin_n = {{(NUM_W-13){1'b0}}, cfg_i.ratio_min};

  always_comb begin
    case (side_i.br)
      BR_UP_DIV: begin
        if (quot_i < ONE_N) rt_ratio_d = ONE_R;
        else if (quot_i > rmax_n) rt_ratio_d = {1'b0, cfg_i.ratio_max};
        else rt_ratio_d = quot_i[AGS_RAT_W-1:0];
      end
      BR_DN_DIV: begin
        if (quot_i < rmin_n) rt_ratio_d = {4'b0, cfg_i.ratio_min};
        else if (quot_i > ONE_N) rt_ratio_d = ONE_R;
        else rt_ratio_d = quot_i[AGS_RAT_W-1:0];
      end
      BR_DN_CLIP: rt_ratio_d = {4'b0, cfg_i.clip_backoff};
      default:    rt_ratio_d = ONE_R;
    endcase
  end

  // Scale the amplitude by the ratio
  assign pm_prod_d = PROD_W'(rt_side_q.amp) * PROD_W'(rt_ratio_q);

  // Pick the wanted amplitude, forcing a rise where the scaled value did not rise
  logic [DES_W-1:0] ds_amp, ds_amp_step, ds_shr;
  assign ds_amp      = {{(DES_W-16){1'b0}}, pm_side_q.amp};
  assign ds_amp_step = ds_amp + {{(DES_W-16){1'b0}}, pm_side_q.step};
  assign ds_shr      = pm_prod_q[PROD_W-1:FRAC_BITS];

  always_comb begin
    case (pm_side_q.br)
      BR_UP_MINV: ds_des_d = ds_amp_step;
      BR_UP_DIV:  ds_des_d = (ds_shr <= ds_amp) ? ds_amp_step : ds_shr;
      BR_DN_CLIP: ds_des_d = ds_shr;
      BR_DN_DIV:  ds_des_d = ds_shr;
      default:    ds_des_d = ds_amp;
    endcase
  end

  // Limit the move to one step either way
  logic [LIM_W-1:0] lm_amp, lm_step, lm_des;
  assign lm_amp  = {{(LIM_W-16){1'b0}}, ds_side_q.amp};
  assign lm_step = {{(LIM_W-16){1'b0}}, ds_side_q.step};
  assign lm_des  = {1'b0, ds_des_q};

  always_comb begin
    if (lm_des > lm_amp + lm_step) begin
      lm_lim_d = $signed(lm_amp + lm_step);
    end else if (lm_amp > lm_des + lm_step) begin
      lm_lim_d = $signed(lm_amp - lm_step);
    end else begin
      lm_lim_d = $signed(lm_des);
    end
  end

  // Clamp to the amplitude range and flag the bounds, except on the pass path
  logic signed [LIM_W-1:0] floor_s, ceil_s;
  logic [15:0]             clamp_v;
  assign floor_s = $signed({{(LIM_W-16){1'b0}}, cfg_i.amp_floor});
  assign ceil_s  = $signed({{(LIM_W-16){1'b0}}, cfg_i.amp_ceiling});

  always_comb begin
    if (lm_lim_q < floor_s) clamp_v = cfg_i.amp_floor;
    else if (lm_lim_q > ceil_s) clamp_v = cfg_i.amp_ceiling;
    else clamp_v = lm_lim_q[15:0];

    if (lm_side_q.br == BR_PASS) begin
      next_amp_d = lm_side_q.amp;
      at_limit_d = 1'b0;
    end else begin
      next_amp_d = clamp_v;
      at_limit_d = (clamp_v <= cfg_i.amp_floor) || (clamp_v >= cfg_i.amp_ceiling);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q <= 1'b0;
      pm_vld_q <= 1'b0;
      ds_vld_q <= 1'b0;
      lm_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      rt_vld_q <= valid_i;
      pm_vld_q <= rt_vld_q;
      ds_vld_q <= pm_vld_q;
      lm_vld_q <= ds_vld_q;
      done_q   <= lm_vld_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    rt_side_q  <= side_i;
    rt_ratio_q <= rt_ratio_d;
    pm_side_q  <= rt_side_q;
    pm_prod_q  <= pm_prod_d;
    ds_side_q  <= pm_side_q;
    ds_des_q   <= ds_des_d;
    lm_side_q  <= ds_side_q;
    lm_lim_q   <= lm_lim_d;
    next_amp_q <= next_amp_d;
    at_limit_q <= at_limit_d;
  end

  assign done_o     = done_q;
  assign next_amp_o = next_amp_q;
  assign at_limit_o = at_limit_q;

endmodule
`default_nettype wire

FILE: hdl/auto_gain_step.sv
// Top level of the gain step block: register file, decode stage and pipeline.
`timescale 1ns / 1ps
`default_nettype none
// One automatic gain control step per measurement. A new measurement is taken
// on every cycle in which start is high; busy stays low, so items may follow
// back to back. Each item yields one result on next_amp_o / at_limit_o, shown
// for exactly one cycle with done_o high. Each item passes the decode stage,
// then the target/RMS divider, a restoring divider of 16+FRAC_BITS stages,
// one quotient bit per stage, followed by ratio clamp, multiply, step select,
// step limit and output clamp stages. The receiver cannot hold results off and
// must take each done_o beat as it comes. Configuration registers sit at byte
// address 4*index on the APB port and are to be written only while no item is
// in flight.
module auto_gain_step #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // command channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic signed [15:0]  measured_rms_i,
  input  wire logic                clipping_i,
  input  wire logic [15:0]         present_amp_i,
  // result channel
  output logic                     done_o,
  output logic [15:0]              next_amp_o,
  output logic                     at_limit_o,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import ags_pkg::*;

  localparam int NUM_W         = 16 + FRAC_BITS;
  localparam int TOL_Q         = ags_round_pct(FRAC_BITS, 2);
  localparam int MINV_Q        = ags_round_pct(FRAC_BITS, 2);
  localparam int COARSE_ERR_Q  = ags_round_pct(FRAC_BITS, 6);
  localparam int COARSE_STEP_Q = ags_round_pct(FRAC_BITS, 8);
  localparam int FINE_STEP_Q   = ags_round_pct(FRAC_BITS, 3);

  localparam logic [16:0] TOL_V    = 17'(TOL_Q);
  localparam logic [16:0] MINV_V   = 17'(MINV_Q);
  localparam logic [16:0] CERR_V   = 17'(COARSE_ERR_Q);
  localparam logic [15:0] CSTEP_V  = 16'(COARSE_STEP_Q);
  localparam logic [15:0] FSTEP_V  = 16'(FINE_STEP_Q);

  // Configuration registers
  logic        enable_q;
  logic [15:0] target_rms_q;
  logic [15:0] ratio_max_q;
  logic [12:0] ratio_min_q;
  logic [12:0] clip_backoff_q;
  logic [15:0] amp_floor_q;
  logic [15:0] amp_ceiling_q;
  logic        apb_wr;
  logic [AGS_IDX_W-1:0] reg_idx;
  ags_cfg_t    cfg;

  assign pready  = 1'b1;
  assign apb_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AGS_ADDR_W-1:2];

  // Write registers on the access beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= 1'b0;
      target_rms_q   <= 16'd4096;
      ratio_max_q    <= 16'd8192;
      ratio_min_q    <= 13'd2048;
      clip_backoff_q <= 13'd2867;
      amp_floor_q    <= 16'd0;
      amp_ceiling_q  <= 16'd40960;
    end else if (apb_wr) begin
      case (reg_idx)
        REG_ENABLE:       enable_q       <= pwdata[0];
        REG_TARGET_RMS:   target_rms_q   <= pwdata[15:0];
        REG_RATIO_MAX:    ratio_max_q    <= pwdata[15:0];
        REG_RATIO_MIN:    ratio_min_q    <= pwdata[12:0];
        REG_CLIP_BACKOFF: clip_backoff_q <= pwdata[12:0];
        REG_AMP_FLOOR:    amp_floor_q    <= pwdata[15:0];
        REG_AMP_CEILING:  amp_ceiling_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_ENABLE:       prdata = {31'b0, enable_q};
      REG_TARGET_RMS:   prdata = {16'b0, target_rms_q};
      REG_RATIO_MAX:    prdata = {16'b0, ratio_max_q};
      REG_RATIO_MIN:    prdata = {19'b0, ratio_min_q};
      REG_CLIP_BACKOFF: prdata = {19'b0, clip_backoff_q};
      REG_AMP_FLOOR:    prdata = {16'b0, amp_floor_q};
      REG_AMP_CEILING:  prdata = {16'b0, amp_ceiling_q};
      default:          prdata = '0;
    endcase
  end

  assign cfg = '{enable:       enable_q,
                 target_rms:   target_rms_q,
                 ratio_max:    ratio_max_q,
                 ratio_min:    ratio_min_q,
                 clip_backoff: clip_backoff_q,
                 amp_floor:    amp_floor_q,
                 amp_ceiling:  amp_ceiling_q};

  // Never stalls
  assign busy = 1'b0;

  // Decode: band test, step size and path
  logic [AGS_RMS_W-1:0] rms_pos;
  logic [16:0]          rms_x, tgt_x;
  logic                 below, above, coarse_up, coarse_dn;
  ags_side_t            s0_side_d, s0_side_q;
  logic                 s0_vld_q;
  logic [NUM_W-1:0]     s0_num_q;
  logic [AGS_RMS_W-1:0] s0_den_q;

  assign rms_pos   = measured_rms_i[15] ? '0 : measured_rms_i[14:0];
  assign rms_x     = {2'b0, rms_pos};
  assign tgt_x     = {1'b0, target_rms_q};
  assign below     = (rms_x + TOL_V) < tgt_x;
  assign above     = rms_x > (tgt_x + TOL_V);
  assign coarse_up = tgt_x > (rms_x + CERR_V);
  assign coarse_dn = rms_x > (tgt_x + CERR_V);

  always_comb begin
    s0_side_d.amp  = present_amp_i;
    s0_side_d.step = FSTEP_V;
    s0_side_d.br   = BR_PASS;
    if (enable_q && below) begin
      s0_side_d.step = coarse_up ? CSTEP_V : FSTEP_V;
      s0_side_d.br   = (rms_x < MINV_V) ? BR_UP_MINV : BR_UP_DIV;
    end else if (enable_q && above) begin
      s0_side_d.step = coarse_dn ? CSTEP_V : FSTEP_V;
      s0_side_d.br   = clipping_i ? BR_DN_CLIP : BR_DN_DIV;
    end
  end

  // Take the command beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_side_q <= s0_side_d;
    s0_num_q  <= {target_rms_q, {FRAC_BITS{1'b0}}};
    s0_den_q  <= rms_pos;
  end

  // Divide target by RMS
  logic             dv_vld;
  logic [NUM_W-1:0] dv_quot;
  ags_side_t        dv_side;

  ags_div #(
    .NUM_W (NUM_W),
    .DEN_W (AGS_RMS_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_vld_q),
    .num_i   (s0_num_q),
    .den_i   (s0_den_q),
    .side_i  (s0_side_q),
    .valid_o (dv_vld),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // Clamp, scale, limit and deliver
  ags_back #(
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NUM_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .valid_i    (dv_vld),
    .quot_i     (dv_quot),
    .side_i     (dv_side),
    .done_o     (done_o),
    .next_amp_o (next_amp_o),
    .at_limit_o (at_limit_o)
  );

endmodule
`default_nettype wire

FILE: hdl/ags_chk.sv
// Port-level checker for the gain step block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ags_chk #(
  parameter int FRAC_BITS = 12
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [15:0] present_amp_i,
  input wire logic        done_o,
  input wire logic [15:0] next_amp_o,
  input wire logic        at_limit_o,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic        pready,
  input wire logic [4:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata
);
  import ags_pkg::*;

  localparam int          LAT     = FRAC_BITS + 22;
  localparam logic [16:0] STEP_V  = 17'(ags_round_pct(FRAC_BITS, 8));

  logic wr;
  assign wr = psel && penable && pwrite && pready;

  // Every accepted command beat gives a result beat after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("result beat missing after command");

  // No result beat without a command beat the fixed latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##LAT !done_o)
    else $error("result beat without command");

  // Off the limits, the amplitude moves at most one coarse step
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !at_limit_o) |->
      (({1'b0, next_amp_o}) <= ({1'b0, $past(present_amp_i, LAT)} + STEP_V)) &&
      (({1'b0, next_amp_o} + STEP_V) >= {1'b0, $past(present_amp_i, LAT)}))
    else $error("amplitude moved more than one step");

  // A written target reads back at the same address
  a_target_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && paddr[4:2] == REG_TARGET_RMS) |=>
      (!(psel && !pwrite && paddr == $past(paddr)) ||
       prdata == {16'b0, $past(pwdata[15:0])}))
    else $error("target register read back differs");

endmodule

bind auto_gain_step ags_chk #(.FRAC_BITS(FRAC_BITS)) u_ags_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .present_amp_i (present_amp_i),
  .done_o        (done_o),
  .next_amp_o    (next_amp_o),
  .at_limit_o    (at_limit_o),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .pready        (pready),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);
`default_nettype wire

FILE: tb/sv/auto_gain_step_test.sv
// Self-checking testbench for the automatic gain control step block.
`timescale 1ns / 1ps
module auto_gain_step_test;
  import ags_pkg::*;

  localparam int     FRAC_BITS   = 12;
  localparam longint UNITY       = longint'(1) << FRAC_BITS;
  localparam longint BAND_TOL    = (UNITY * 2 + 50) / 100;
  localparam longint MIN_RMS     = (UNITY * 2 + 50) / 100;
  localparam longint COARSE_ERR  = (UNITY * 6 + 50) / 100;
  localparam longint COARSE_STEP = (UNITY * 8 + 50) / 100;
  localparam longint FINE_STEP   = (UNITY * 3 + 50) / 100;
  localparam int     TAIL_CYCLES = 40;

  typedef struct {
    logic [15:0] next_amp;
    logic        at_limit;
  } gain_result_t;

  // Predicts each gain step and checks the results in order
  class gain_scoreboard;
    bit             enable;
    logic [15:0]    target_rms;
    logic [15:0]    ratio_max;
    logic [12:0]    ratio_min;
    logic [12:0]    clip_backoff;
    logic [15:0]    amp_floor;
    logic [15:0]    amp_ceiling;
    gain_result_t   expected_q[$];
    int             mismatches;

    function new();
      enable       = 1'b0;
      target_rms   = 16'd4096;
      ratio_max    = 16'd8192;
      ratio_min    = 13'd2048;
      clip_backoff = 13'd2867;
      amp_floor    = 16'd0;
      amp_ceiling  = 16'd40960;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [AGS_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_ENABLE:       enable       = value[0];
        REG_TARGET_RMS:   target_rms   = value[15:0];
        REG_RATIO_MAX:    ratio_max    = value[15:0];
        REG_RATIO_MIN:    ratio_min    = value[12:0];
        REG_CLIP_BACKOFF: clip_backoff = value[12:0];
        REG_AMP_FLOOR:    amp_floor    = value[15:0];
        REG_AMP_CEILING:  amp_ceiling  = value[15:0];
        default: ;
      endcase
    endfunction

    // Lower bound wins when the bounds cross
    function longint clamp_range(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function gain_result_t compute_step(logic signed [15:0] rms_in, logic clip,
                                        logic [15:0] amp_in);
      gain_result_t r;
      longint rms, amp, tgt, step, err, ratio, desired, lo, hi;
      rms = rms_in;
      amp = longint'(amp_in);
      tgt = longint'(target_rms);
      lo  = longint'(amp_floor);
      hi  = longint'(amp_ceiling);
      r.next_amp = amp_in;
      r.at_limit = 1'b0;
      if (!enable) return r;
      if (rms < 0) rms = 0;

      if (rms < tgt - BAND_TOL) begin
        // below band: raise by target/RMS, or by a fixed step at very low RMS
        err  = tgt - rms;
        step = (err > COARSE_ERR) ? COARSE_STEP : FINE_STEP;
        if (rms < MIN_RMS) begin
          desired = amp + step;
        end else begin
          ratio   = clamp_range((tgt << FRAC_BITS) / rms, UNITY, longint'(ratio_max));
          desired = (amp * ratio) >>> FRAC_BITS;
        end
        if (desired <= amp) desired = amp + step;
      end else if (rms > tgt + BAND_TOL) begin
        // above band: back off on clipping, else lower by target/RMS
        err  = rms - tgt;
        step = (err > COARSE_ERR) ? COARSE_STEP : FINE_STEP;
        if (clip) begin
          desired = (amp * longint'(clip_backoff)) >>> FRAC_BITS;
        end else begin
          ratio   = clamp_range((tgt << FRAC_BITS) / rms, longint'(ratio_min), UNITY);
          desired = (amp * ratio) >>> FRAC_BITS;
        end
      end else begin
        return r;
      end

      // limit the move to one step
      if (desired > amp) begin
        if (desired - amp > step) desired = amp + step;
      end else if (amp - desired > step) begin
        desired = amp - step;
      end

      desired    = clamp_range(desired, lo, hi);
      r.next_amp = desired[15:0];
      r.at_limit = (desired <= lo || desired >= hi);
      return r;
    endfunction

    function void note_item(logic signed [15:0] rms_in, logic clip, logic [15:0] amp_in);
      expected_q.push_back(compute_step(rms_in, clip, amp_in));
    endfunction

    function void check_result(logic [15:0] next_amp, logic at_limit);
      gain_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: next_amp %0d at_limit %0b",
                 $time, next_amp, at_limit);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (next_amp !== want.next_amp) begin
        $display("%0t: next_amp mismatch: expected %0d actual %0d",
                 $time, want.next_amp, next_amp);
        mismatches++;
      end
      if (at_limit !== want.at_limit) begin
        $display("%0t: at_limit mismatch: expected %0b actual %0b",
                 $time, want.at_limit, at_limit);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic signed [15:0] measured_rms_i = '0;
  logic               clipping_i     = 1'b0;
  logic [15:0]        present_amp_i  = '0;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [4:0]         paddr          = '0;
  logic [31:0]        pwdata         = '0;
  wire                busy;
  wire                done_o;
  wire  [15:0]        next_amp_o;
  wire                at_limit_o;
  wire  [31:0]        prdata;
  wire                pready;

  gain_scoreboard gains = new();

  auto_gain_step #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .measured_rms_i (measured_rms_i),
    .clipping_i     (clipping_i),
    .present_amp_i  (present_amp_i),
    .done_o         (done_o),
    .next_amp_o     (next_amp_o),
    .at_limit_o     (at_limit_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Check every result beat at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && done_o) gains.check_result(next_amp_o, at_limit_o);
  end

  // Drive one measurement after an optional gap and note it once accepted
  task automatic send_item(input logic signed [15:0] rms, input logic clip,
                           input logic [15:0] amp, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    measured_rms_i <= rms;
    clipping_i     <= clip;
    present_amp_i  <= amp;
    do @(posedge clk_i); while (busy);
    gains.note_item(rms, clip, amp);
  endtask

  // Hold off new items until every expected result has come
  task automatic drain_results();
    start <= 1'b0;
    while (gains.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [AGS_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    gains.write_reg(idx, value);
  endtask

  task automatic apply_setting(input int en, input int tgt, input int rmax, input int rmin,
                               input int backoff, input int lo, input int hi);
    drain_results();
    write_reg(REG_ENABLE,       en);
    write_reg(REG_TARGET_RMS,   tgt);
    write_reg(REG_RATIO_MAX,    rmax);
    write_reg(REG_RATIO_MIN,    rmin);
    write_reg(REG_CLIP_BACKOFF, backoff);
    write_reg(REG_AMP_FLOOR,    lo);
    write_reg(REG_AMP_CEILING,  hi);
  endtask

  // Often near the band edges and step thresholds, also very low, some full range
  function automatic logic [15:0] pick_rms(input int tgt);
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom);
      2:       return 16'($urandom_range(0, 100));
      3, 4, 5, 6: return 16'(tgt + int'($urandom_range(0, 700)) - 350);
      default: return 16'($urandom_range(0, 2 * tgt + 200));
    endcase
  endfunction

  function automatic logic [15:0] pick_amp(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0, 1:    return 16'($urandom);
      2:       return 16'($urandom_range(0, 8192));
      default: return 16'(($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 800)) - 400);
    endcase
  endfunction

  task automatic run_random(input int count);
    int n;
    bit burst;
    burst = 1'b0;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 15) == 0) burst = !burst;
      if ($urandom_range(0, 49) == 0) drain_results();
      send_item(pick_rms(int'(gains.target_rms)), 1'($urandom_range(0, 1)),
                pick_amp(int'(gains.amp_floor), int'(gains.amp_ceiling)), burst);
    end
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values, block disabled: amplitude passes through
    send_item(-16'sd32768, 1'b1, 16'hFFFF, 1'b0);
    send_item(16'sd32767, 1'b0, 16'h0000, 1'b0);
    send_item(16'sd4096, 1'b1, 16'h0001, 1'b0);
    run_random(20);

    // enabled with reset values: band edges, step sizes and clamps
    apply_setting(1, 4096, 8192, 2048, 2867, 0, 40960);
    send_item(-16'sd32768, 1'b0, 16'd0, 1'b0);
    send_item(16'sd0, 1'b0, 16'hFFFF, 1'b0);
    send_item(16'sd81, 1'b1, 16'd4096, 1'b0);
    send_item(16'sd82, 1'b0, 16'd4096, 1'b0);
    send_item(16'sd2048, 1'b0, 16'd4096, 1'b0);
    send_item(16'sd4014, 1'b0, 16'd1000, 1'b0);
    send_item(16'sd4013, 1'b0, 16'd1000, 1'b0);
    send_item(16'sd4178, 1'b1, 16'd30000, 1'b0);
    send_item(16'sd4179, 1'b0, 16'd30000, 1'b0);
    send_item(16'sd3850, 1'b0, 16'd20000, 1'b0);
    send_item(16'sd3849, 1'b0, 16'd20000, 1'b0);
    send_item(16'sd4342, 1'b1, 16'd20000, 1'b0);
    send_item(16'sd4343, 1'b1, 16'd20000, 1'b0);
    send_item(16'sd32767, 1'b0, 16'hFFFF, 1'b0);
    send_item(16'sd32767, 1'b1, 16'd0, 1'b0);
    send_item(16'sd4096, 1'b1, 16'd12345, 1'b0);
    send_item(16'sd3000, 1'b0, 16'd0, 1'b0);
    send_item(-16'sd1, 1'b1, 16'd40960, 1'b0);
    send_item(16'sd5000, 1'b0, 16'd100, 1'b0);
    run_random(60);

    // all registers at their top values
    apply_setting(1, 65535, 65535, 8191, 8191, 65535, 65535);
    run_random(60);

    // all registers zero but enable
    apply_setting(1, 0, 0, 0, 0, 0, 0);
    run_random(60);

    // target under the tolerance, ratio_max under one, floor over ceiling
    apply_setting(1, 50, 1000, 4096, 4096, 50000, 1000);
    run_random(60);

    // disabled with odd limits
    apply_setting(0, $urandom_range(0, 16384), $urandom, 0, 8191, 60000, 10);
    run_random(30);

    for (k = 0; k < 7; k++) begin
      apply_setting(int'($urandom_range(0, 7) != 0), $urandom_range(0, 16384),
                    $urandom_range(4096, 65535), $urandom_range(0, 4096),
                    $urandom_range(0, 4096), $urandom_range(0, 8192),
                    $urandom_range(16384, 65535));
      run_random(60);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (gains.mismatches == 0 && gains.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
